### hw/rtl/clpf_pkg.sv
// ---------------------------------------------------------------------------
// clpf_pkg
// Shared types and constants for the cascaded low-pass filter.
// ---------------------------------------------------------------------------
package clpf_pkg;

    // Coefficient in unsigned Q1.15; the constant 1.0 is declared one bit wider
    localparam int COEF_W = 16;
    localparam logic [COEF_W:0] COEF_ONE = 17'd32768;

    // Stage count register and its clamped form (room for a count of 16)
    localparam int STAGE_CNT_W = 4;
    localparam int CNT_W       = STAGE_CNT_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_COEFF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGES_IN_USE   = 1'd1;

    // Blend rounding: shift out the Q1.15 fraction, round half up
    localparam int BLEND_FRAC = 15;
    localparam int BLEND_HALF = 16384;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // Controls broadcast to every cell of the chain
    typedef struct packed {
        logic              prime;
        logic [COEF_W:0]   coeff;
    } cell_ctrl_t;

endpackage

### hw/rtl/clpf_cell.sv
// ---------------------------------------------------------------------------
// clpf_cell
// One first-order low-pass stage: two blends through one shared multiplier,
// first the input blend, then the output blend, and hand the result on.
// ---------------------------------------------------------------------------
module clpf_cell
    import clpf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] prime_sample,
    input  logic                          valid_in,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    output logic                          valid_out,
    output logic signed [SAMPLE_BITS-1:0] y_out
);

    localparam int PROD_W = SAMPLE_BITS + COEF_W + 3;

    logic signed [SAMPLE_BITS-1:0] xp_reg;
    logic signed [SAMPLE_BITS-1:0] yp_reg;
    logic signed [SAMPLE_BITS-1:0] x_hold_reg;
    logic signed [SAMPLE_BITS-1:0] m_reg;
    logic                          ph2_reg;
    logic                          valid_out_reg;

    logic signed [SAMPLE_BITS-1:0] op_p;
    logic signed [SAMPLE_BITS-1:0] op_q;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      rnd;
    logic signed [PROD_W-1:0]      shifted;
    logic signed [SAMPLE_BITS-1:0] blend_val;

    // blend(p, q) = q + round(a * (p - q) / 2^15)
    always_comb
    begin
        op_p      = ph2_reg ? m_reg : x_in;
        op_q      = ph2_reg ? yp_reg : xp_reg;
        diff      = {op_p[SAMPLE_BITS-1], op_p} - {op_q[SAMPLE_BITS-1], op_q};
        prod      = PROD_W'($signed({1'b0, ctrl.coeff})) * PROD_W'(diff);
        rnd       = prod + PROD_W'(BLEND_HALF);
        shifted   = rnd >>> BLEND_FRAC;
        blend_val = op_q + $signed(shifted[SAMPLE_BITS-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph2_reg       <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            ph2_reg       <= valid_in;
            valid_out_reg <= ph2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prime)
        begin
            xp_reg <= prime_sample;
            yp_reg <= prime_sample;
        end
        else if (ph2_reg)
        begin
            // second half: commit the stage state
            xp_reg <= x_hold_reg;
            yp_reg <= blend_val;
        end
        if (valid_in && !ph2_reg)
        begin
            m_reg      <= blend_val;
            x_hold_reg <= x_in;
        end
    end

    assign valid_out = valid_out_reg;
    assign y_out     = yp_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(valid_in && ph2_reg))
        else $error("clpf_cell: new beat while second blend in progress");

    a_prime_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.prime |-> !valid_in && !ph2_reg && !valid_out_reg)
        else $error("clpf_cell: prime while a beat is in flight");

    a_out_after_ph2: assert property (@(posedge clk) disable iff (!rst_n)
        valid_in |=> ph2_reg ##1 valid_out_reg)
        else $error("clpf_cell: result not produced two cycles after entry");

endmodule

### hw/rtl/cascaded_lowpass_filter.sv
// ---------------------------------------------------------------------------
// cascaded_lowpass_filter
// Cascade of first-order IIR low-pass cells with a clamped stage count and
// coefficient, a result holding stage and a registered output.
// ---------------------------------------------------------------------------
// A sample walks the n cells in use (n = stages in use), two blends per cell done in
// turn through each cell's single multiplier, then the result holding stage and the
// output register; the first sample after reset primes every cell and passes unchanged.
// A new sample is taken only once the last one has left the holding stage (in_stall).
// Reset: coefficient 1.0, one stage, chain unprimed; no clearing pass.
module cascaded_lowpass_filter
    import clpf_pkg::*;
#(
    parameter int MAX_STAGES  = 8,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [COEF_W-1:0]             cfg_data
);

    logic [COEF_W-1:0]             coeff_reg;
    logic [STAGE_CNT_W-1:0]        stages_reg;
    state_t                        state_reg;
    state_t                        state_next;
    logic                          primed_reg;
    logic signed [SAMPLE_BITS-1:0] hold_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic [COEF_W:0]               coeff_sat;
    logic [CNT_W-1:0]              n_clamp;
    logic [CNT_W-1:0]              last_idx;
    cell_ctrl_t                    ctrl;

    logic                          start;
    logic                          prime;
    logic                          hold_load;
    logic                          hold_from_sample;
    logic                          out_load;

    logic [MAX_STAGES-1:0]         is_last;
    logic [MAX_STAGES-1:0]         cell_vin;
    logic [MAX_STAGES-1:0]         cell_vout;
    logic signed [SAMPLE_BITS-1:0] cell_xin [MAX_STAGES];
    logic signed [SAMPLE_BITS-1:0] cell_y   [MAX_STAGES];
    logic                          res_valid;
    logic signed [SAMPLE_BITS-1:0] res_y;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg  <= COEF_ONE[COEF_W-1:0];
            stages_reg <= STAGE_CNT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SMOOTHING_COEFF: coeff_reg  <= cfg_data;
                CFG_STAGES_IN_USE:   stages_reg <= cfg_data[STAGE_CNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Clamp coefficient to 1.0 and stage count to 1..MAX_STAGES
    always_comb
    begin
        coeff_sat = (coeff_reg > COEF_ONE[COEF_W-1:0]) ? COEF_ONE : {1'b0, coeff_reg};
        if (stages_reg == '0)
            n_clamp = CNT_W'(1);
        else if ({1'b0, stages_reg} > CNT_W'(MAX_STAGES))
            n_clamp = CNT_W'(MAX_STAGES);
        else
            n_clamp = {1'b0, stages_reg};
        last_idx   = n_clamp - CNT_W'(1);
        ctrl.prime = prime;
        ctrl.coeff = coeff_sat;
    end

    // Chain of cells
    for (genvar i = 0; i < MAX_STAGES; i++)
    begin : g_cell
        assign is_last[i] = (last_idx == CNT_W'(i));
        if (i == 0)
        begin : g_head
            assign cell_vin[i] = start;
            assign cell_xin[i] = sample_in;
        end
        else
        begin : g_body
            assign cell_vin[i] = cell_vout[i-1] & ~is_last[i-1];
            assign cell_xin[i] = cell_y[i-1];
        end

        clpf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .prime_sample (sample_in),
            .valid_in     (cell_vin[i]),
            .x_in         (cell_xin[i]),
            .valid_out    (cell_vout[i]),
            .y_out        (cell_y[i])
        );
    end

    // Pick the result of the last stage in use
    always_comb
    begin
        res_valid = 1'b0;
        res_y     = cell_y[0];
        for (int i = 0; i < MAX_STAGES; i++)
        begin
            if (cell_vout[i] && is_last[i])
            begin
                res_valid = 1'b1;
                res_y     = cell_y[i];
            end
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        start            = 1'b0;
        prime            = 1'b0;
        hold_load        = 1'b0;
        hold_from_sample = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!primed_reg)
                    begin
                        // first sample: prime every cell and pass it straight out
                        prime            = 1'b1;
                        hold_load        = 1'b1;
                        hold_from_sample = 1'b1;
                        state_next       = ST_HOLD;
                    end
                    else
                    begin
                        start      = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (res_valid)
                begin
                    hold_load  = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (prime)
                primed_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_load)
            hold_reg <= hold_from_sample ? sample_in : res_y;
        if (out_load)
            sample_out_reg <= hold_reg;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    a_one_cell_active: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_vout))
        else $error("cascaded_lowpass_filter: more than one cell finishing");

    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> state_reg == ST_RUN)
        else $error("cascaded_lowpass_filter: result outside run state");

    a_start_primed: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> primed_reg)
        else $error("cascaded_lowpass_filter: chain started before priming");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
        else $error("cascaded_lowpass_filter: output overwritten while stalled");

endmodule

### test/cascaded_lowpass_filter_tb.sv
// ---------------------------------------------------------------------------
// cascaded_lowpass_filter_tb
// Self-checking bench for the cascaded low-pass filter. Samples stream through
// a valid/stall channel with random gaps and output back-pressure. A bit-exact
// model of the stage chain predicts every filtered sample. Coefficient and
// stage count are changed between phases while the filter is idle.
// ---------------------------------------------------------------------------
module cascaded_lowpass_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clpf_pkg::*;

    localparam int MAX_STAGES  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 29;
    localparam int PHASE_ITEMS = 50;
    localparam int PHASES      = 14;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    class sample_scoreboard;
        logic [COEF_W-1:0]      coeff_reg;
        logic [STAGE_CNT_W-1:0] stage_reg;
        longint                 last_in  [MAX_STAGES];
        longint                 last_out [MAX_STAGES];
        bit                     primed;
        sample_t                filtered_q [$];
        int                     errors;

        function new();
            coeff_reg = COEF_ONE[COEF_W-1:0];
            stage_reg = STAGE_CNT_W'(1);
            primed    = 0;
            errors    = 0;
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                last_in[i]  = 0;
                last_out[i] = 0;
            end
        endfunction

        // round((a*p + (1-a)*q) / 2^15), ties upward
        function longint blend(longint a, longint p, longint q);
            longint s;
            s = a * p + (longint'(COEF_ONE) - a) * q;
            return (s + BLEND_HALF) >>> BLEND_FRAC;
        endfunction

        function void note_input(sample_t x_in);
            longint a;
            longint x;
            longint m;
            int     n;
            x = longint'(x_in);
            a = (coeff_reg > COEF_ONE) ? longint'(COEF_ONE) : longint'(coeff_reg);
            n = int'(stage_reg);
            if (n == 0)
                n = 1;
            if (n > MAX_STAGES)
                n = MAX_STAGES;
            if (!primed)
            begin
                // prime every stage, including those not in use
                for (int i = 0; i < MAX_STAGES; i++)
                begin
                    last_in[i]  = x;
                    last_out[i] = x;
                end
                primed = 1;
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    m           = blend(a, x, last_in[i]);
                    last_in[i]  = x;
                    x           = blend(a, m, last_out[i]);
                    last_out[i] = x;
                end
            end
            filtered_q.push_back(sample_t'(x));
        endfunction

        function void check_result(sample_t got);
            sample_t want;
            if (filtered_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("sample_out %0d with no sample pending", got);
                return;
            end
            want = filtered_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("sample_out mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    sample_t              sample_in;
    logic                 out_valid;
    logic                 out_stall;
    sample_t              sample_out;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    sample_scoreboard     board;
    bit                   steady;
    int                   cycle_count;

    cascaded_lowpass_filter #(
        .MAX_STAGES  (MAX_STAGES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    // Output back-pressure
    always @(negedge clk)
        out_stall <= rst_n && !steady && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            board.check_result(sample_out);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_sample(input sample_t x);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(x);
    endtask

    // Hold off until every pending sample is out and the chain has settled
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.filtered_q.size() != 0)
            @(posedge clk);
        repeat (2 * MAX_STAGES + 4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_SMOOTHING_COEFF)
            board.coeff_reg = data;
        else
            board.stage_reg = data[STAGE_CNT_W-1:0];
    endtask

    task automatic configure(input logic [COEF_W-1:0] coeff, input logic [COEF_W-1:0] stages);
        drain();
        write_reg(CFG_SMOOTHING_COEFF, coeff);
        write_reg(CFG_STAGES_IN_USE, stages);
    endtask

    task automatic random_phase();
        int                r;
        logic [COEF_W-1:0] coeff;
        logic [COEF_W-1:0] stages;
        sample_t           s;
        sample_t           prev;
        r = $urandom_range(0, 9);
        if (r < 6)
            coeff = COEF_W'($urandom_range(0, 32768));
        else if (r == 6)
            coeff = COEF_ONE[COEF_W-1:0];
        else if (r == 7)
            coeff = '0;
        else if (r == 8)
            coeff = COEF_W'($urandom_range(32769, 65535));
        else
            coeff = COEF_W'($urandom_range(1, 64));
        // upper data bits are random; only the low nibble counts
        stages = COEF_W'($urandom);
        r = $urandom_range(0, 9);
        if (r < 8)
            stages[STAGE_CNT_W-1:0] = STAGE_CNT_W'($urandom_range(1, MAX_STAGES));
        else if (r == 8)
            stages[STAGE_CNT_W-1:0] = '0;
        else
            stages[STAGE_CNT_W-1:0] = STAGE_CNT_W'($urandom_range(MAX_STAGES + 1, 15));
        configure(coeff, stages);
        prev = sample_t'($urandom);
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                s = sample_t'($urandom);
            else if (r < 7)
                s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            else if (r < 9)
                s = prev + sample_t'($urandom_range(0, 512)) - 16'sd256;
            else
                s = prev;
            send_sample(s);
            prev = s;
        end
    endtask

    initial
    begin
        board     = new();
        steady    = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample_in = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;

        // First sample primes the chain and passes straight through
        send_sample(16'sh8000);
        send_sample(16'sh7fff);

        // Zero coefficient, full chain: outputs freeze on held state
        configure(16'd0, 16'd8);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd0);

        // Coefficient and stage count above range saturate
        configure(16'hffff, 16'hffff);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh7fff);

        // Stage count of zero acts as one stage
        configure(16'd16384, 16'd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd0);

        // Re-enable idle stages: they resume from their old state
        configure(16'd1, 16'd8);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh8000);

        configure(16'd32767, 16'd5);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd12345);

        for (int p = 0; p < PHASES; p++)
        begin
            steady = (p == 4 || p == 5);
            random_phase();
        end
        steady = 0;
        drain();

        if (board.errors == 0 && board.filtered_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
